// ----- src/lcgrd_pkg.sv -----
// Shared types and constants for the random range draw block.
package lcgrd_pkg;

  // Width of the seed, range and random value fields on the channels.
  localparam int unsigned FIELD_BITS = 64;

  // Default internal word width of the generator.
  localparam int unsigned WORD_BITS_DEF = 64;

  // Width of the recurrence constants.
  localparam int unsigned KBITS = 24;

  // Width of one long-division digit in the reductions by the recurrence constants.
  localparam int unsigned DIGIT_BITS = 8;

  // Width of the reciprocal constants.
  localparam int unsigned RBITS = 9;

  // Recurrence constants: multiplier, modulus of the mod term, divisor of the div term.
  localparam logic [KBITS-1:0] MUL_K = 24'd9065531;
  localparam logic [KBITS-1:0] MOD_K = 24'd9065533;
  localparam logic [KBITS-1:0] DIV_K = 24'd9065531;

  // Reciprocals floor(2^32 / divisor) of the two divisors. A digit estimate taken with them
  // is never high and at most one low.
  localparam logic [RBITS-1:0] RCP_MOD_K = 9'd473;
  localparam logic [RBITS-1:0] RCP_DIV_K = 9'd473;

  // Request opcodes.
  typedef enum logic [0:0] {
    OP_DRAW = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CEST,
    ST_CFIX,
    ST_PROD,
    ST_MIX,
    ST_MODR,
    ST_DONE
  } state_t;

  // Status of the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- src/lcgrd_if.sv -----
// Request and result channel interfaces of the random range draw block.
interface lcgrd_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [lcgrd_pkg::FIELD_BITS-1:0]  seed_value;
  logic [lcgrd_pkg::FIELD_BITS-1:0]  range_limit;

  modport source (output valid, output opcode, output seed_value, output range_limit,
                  input ready);
  modport sink   (input valid, input opcode, input seed_value, input range_limit,
                  output ready);
endinterface

interface lcgrd_out_if;
  logic                              valid;
  logic                              ready;
  logic [lcgrd_pkg::FIELD_BITS-1:0]  random_value;
  logic                              range_fault;

  modport source (output valid, output random_value, output range_fault, input ready);
  modport sink   (input valid, input random_value, input range_fault, output ready);
endinterface

// ----- src/lcgrd_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, used for the remainder by the range.
module lcgrd_div #(
  parameter int unsigned W = lcgrd_pkg::WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [W-1:0]          dividend,
  input  logic [W-1:0]          divisor,
  output logic [W-1:0]          quotient,
  output logic [W-1:0]          remainder,
  output lcgrd_pkg::div_stat_t  stat
);

  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dsr_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fits;

  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    diff    = shifted - {1'b0, dsr_r};
    fits    = ~diff[W];
    rem_nxt = fits ? diff[W-1:0] : shifted[W-1:0];
    quo_nxt = {quo_r[W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
      cnt_r <= CW'(W - 1);
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ----- src/lcg_random_range_draw.sv -----
// Top level of the random range draw block: seed register, sequencer and output register.
// A draw runs eight radix-256 digit steps by both recurrence constants, forms the new seed in
// ST_PROD and ST_MIX and then takes it modulo the range on the radix-2 divider; a zero range
// skips the divider. The block takes one request at a time: a draw holds off the next request
// until its result goes to the output register, and while idle a load is taken every cycle with
// no result. Reset clears the seed to zero and empties the block.
module lcg_random_range_draw #(
  parameter int unsigned WORD_BITS = lcgrd_pkg::WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lcgrd_in_if.sink    in_chan,
  lcgrd_out_if.source out_chan
);

  localparam int unsigned W    = WORD_BITS;
  localparam int unsigned KB   = lcgrd_pkg::KBITS;
  localparam int unsigned DB   = lcgrd_pkg::DIGIT_BITS;
  localparam int unsigned RB   = lcgrd_pkg::RBITS;
  localparam int unsigned FB   = lcgrd_pkg::FIELD_BITS;
  localparam int unsigned XB   = KB + DB;
  localparam int unsigned PB   = XB + RB;
  localparam int unsigned NDIG = FB / DB;
  localparam int unsigned CB   = $clog2(NDIG);

  lcgrd_pkg::state_t state_r, state_nxt;

  // Generator state and per-request working registers.
  logic [W-1:0]      seed_r, seed_nxt;
  logic [W-1:0]      range_r, range_nxt;
  logic [2*KB-1:0]   prod_r, prod_nxt;
  logic [W-1:0]      res_r, res_nxt;
  logic              fault_r, fault_nxt;

  // Long division of the seed by the two recurrence constants, one byte per step. Seed bytes
  // leave the shift register at the top while quotient bytes of the div term enter at the bottom.
  logic [FB-1:0]     sh_r, sh_nxt;
  logic [KB-1:0]     remq_r, remq_nxt;
  logic [KB-1:0]     remm_r, remm_nxt;
  logic [DB-1:0]     estq_r, estq_nxt;
  logic [DB-1:0]     estm_r, estm_nxt;
  logic [CB-1:0]     dig_r, dig_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [W-1:0]      out_value_r, out_value_nxt;
  logic              out_fault_r, out_fault_nxt;

  // Divider hookup.
  logic                 div_start;
  logic [W-1:0]         div_dividend;
  logic [W-1:0]         div_divisor;
  logic [W-1:0]         div_quotient;
  logic [W-1:0]         div_remainder;
  lcgrd_pkg::div_stat_t div_stat;

  // Digit step terms for the div term (q) and the mod term (m).
  logic [XB-1:0] xq, xm;
  logic [PB-1:0] pq, pm;
  logic [XB-1:0] tq, tm;
  logic [XB-1:0] tq_red, tm_red;
  logic          fq, fm;
  logic [DB-1:0] digq;

  logic in_accept;
  logic [W-1:0] mixed_seed;

  assign in_chan.ready = (state_r == lcgrd_pkg::ST_IDLE);
  assign in_accept     = in_chan.valid && in_chan.ready;

  // The partial dividend of a step is the running remainder with the next seed byte below it.
  // It stays under 256 times the divisor, so the digit is at most 255.
  assign xq = {remq_r, sh_r[FB-1 -: DB]};
  assign xm = {remm_r, sh_r[FB-1 -: DB]};

  // Digit estimate by reciprocal multiplication; it is exact or one low.
  assign pq = {{RB{1'b0}}, xq} * {{XB{1'b0}}, lcgrd_pkg::RCP_DIV_K};
  assign pm = {{RB{1'b0}}, xm} * {{XB{1'b0}}, lcgrd_pkg::RCP_MOD_K};

  // What is left after the estimate is below twice the divisor, so one compare and subtract
  // settles the digit and the remainder.
  assign tq     = xq - {{KB{1'b0}}, estq_r} * {{DB{1'b0}}, lcgrd_pkg::DIV_K};
  assign tm     = xm - {{KB{1'b0}}, estm_r} * {{DB{1'b0}}, lcgrd_pkg::MOD_K};
  assign fq     = (tq >= {{DB{1'b0}}, lcgrd_pkg::DIV_K});
  assign fm     = (tm >= {{DB{1'b0}}, lcgrd_pkg::MOD_K});
  assign tq_red = fq ? tq - {{DB{1'b0}}, lcgrd_pkg::DIV_K} : tq;
  assign tm_red = fm ? tm - {{DB{1'b0}}, lcgrd_pkg::MOD_K} : tm;
  assign digq   = fq ? estq_r + DB'(1) : estq_r;

  // Closing step of the recurrence: product of the mod term minus twice the div term, plus one.
  assign mixed_seed = W'(prod_r) - {sh_r[W-2:0], 1'b0} + W'(1);

  // The divider only ever reduces the new seed by the requested range.
  assign div_dividend = mixed_seed;
  assign div_divisor  = range_r;

  lcgrd_div #(
    .W (W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quotient),
    .remainder (div_remainder),
    .stat      (div_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    seed_nxt      = seed_r;
    range_nxt     = range_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    fault_nxt     = fault_r;
    sh_nxt        = sh_r;
    remq_nxt      = remq_r;
    remm_nxt      = remm_r;
    estq_nxt      = estq_r;
    estm_nxt      = estm_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_fault_nxt = out_fault_r;
    div_start     = 1'b0;

    // A waiting result leaves once the sink takes it.
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      lcgrd_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_chan.opcode == lcgrd_pkg::OP_LOAD) begin
            seed_nxt = in_chan.seed_value[W-1:0];
          end else begin
            // Start the byte-wise long division of the seed by both constants.
            range_nxt = in_chan.range_limit[W-1:0];
            sh_nxt    = FB'(seed_r);
            remq_nxt  = '0;
            remm_nxt  = '0;
            dig_nxt   = '0;
            state_nxt = lcgrd_pkg::ST_CEST;
          end
        end
      end
      lcgrd_pkg::ST_CEST: begin
        estq_nxt  = pq[XB +: DB];
        estm_nxt  = pm[XB +: DB];
        state_nxt = lcgrd_pkg::ST_CFIX;
      end
      lcgrd_pkg::ST_CFIX: begin
        remq_nxt = tq_red[KB-1:0];
        remm_nxt = tm_red[KB-1:0];
        sh_nxt   = {sh_r[FB-DB-1:0], digq};
        dig_nxt  = dig_r + CB'(1);
        if (dig_r == CB'(NDIG - 1)) begin
          state_nxt = lcgrd_pkg::ST_PROD;
        end else begin
          state_nxt = lcgrd_pkg::ST_CEST;
        end
      end
      lcgrd_pkg::ST_PROD: begin
        // The mod term is below the 24-bit modulus, so a narrow multiply covers it.
        prod_nxt  = {{KB{1'b0}}, lcgrd_pkg::MUL_K} * {{KB{1'b0}}, remm_r};
        state_nxt = lcgrd_pkg::ST_MIX;
      end
      lcgrd_pkg::ST_MIX: begin
        seed_nxt = mixed_seed;
        if (range_r == '0) begin
          // Zero range: the seed still advances, the result is zero with the fault flag.
          res_nxt   = '0;
          fault_nxt = 1'b1;
          state_nxt = lcgrd_pkg::ST_DONE;
        end else begin
          // New seed modulo the requested range on the divider.
          div_start = 1'b1;
          state_nxt = lcgrd_pkg::ST_MODR;
        end
      end
      lcgrd_pkg::ST_MODR: begin
        if (div_stat.done) begin
          res_nxt   = div_remainder;
          fault_nxt = 1'b0;
          state_nxt = lcgrd_pkg::ST_DONE;
        end
      end
      lcgrd_pkg::ST_DONE: begin
        // Hand the result to the output register once it is free or being emptied.
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          out_fault_nxt = fault_r;
          state_nxt     = lcgrd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lcgrd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcgrd_pkg::ST_IDLE;
      seed_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    range_r     <= range_nxt;
    prod_r      <= prod_nxt;
    res_r       <= res_nxt;
    fault_r     <= fault_nxt;
    sh_r        <= sh_nxt;
    remq_r      <= remq_nxt;
    remm_r      <= remm_nxt;
    estq_r      <= estq_nxt;
    estm_r      <= estm_nxt;
    dig_r       <= dig_nxt;
    out_value_r <= out_value_nxt;
    out_fault_r <= out_fault_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.random_value = FB'(out_value_r);
  assign out_chan.range_fault  = out_fault_r;

  // A faulted result always carries a zero value.
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.range_fault |-> out_chan.random_value == '0)
    else $error("range fault with nonzero value");

  // A load request lands in the seed register on the next cycle.
  a_load_seed: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_chan.opcode == lcgrd_pkg::OP_LOAD
      |=> seed_r == $past(in_chan.seed_value[W-1:0]))
    else $error("seed load lost");

  // The divider only finishes while the sequencer waits on it.
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == lcgrd_pkg::ST_MODR)
    else $error("divider finished with no pass pending");

  // A finished draw with a nonzero range stays below that range.
  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lcgrd_pkg::ST_DONE && !fault_r |-> res_r < range_r)
    else $error("draw result not below range");

endmodule
